[src/twc_pkg.sv]
// Package for the triangle wave channel: transfer types, event and register
// codes, and the wave and length lookup functions. No dependencies.
package twc_pkg;

  typedef enum logic [1:0] {
    FUNC_WRITE   = 2'd0,
    FUNC_TIMER   = 2'd1,
    FUNC_QUARTER = 2'd2,
    FUNC_HALF    = 2'd3
  } func_e;

  localparam logic [1:0] REG_LINEAR    = 2'd0;
  localparam logic [1:0] REG_PERIOD_LO = 2'd1;
  localparam logic [1:0] REG_UNUSED    = 2'd2;
  localparam logic [1:0] REG_LENGTH    = 2'd3;

  typedef struct packed {
    func_e       func;
    logic [1:0]  reg_addr;
    logic [7:0]  write_data;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  level;
    logic [10:0] timer_period;
    logic        length_active;
    logic        linear_active;
  } out_item_t;

  // Falling ramp 15..0 over the first half, rising ramp 0..15 over the second
  function automatic logic [3:0] wave_level(input logic [4:0] step);
    wave_level = step[4] ? step[3:0] : ~step[3:0];
  endfunction

  // Length counter load values
  function automatic logic [7:0] length_lookup(input logic [4:0] idx);
    logic [7:0] val;
    unique case (idx)
      5'd0:  val = 8'd10;
      5'd1:  val = 8'd254;
      5'd2:  val = 8'd20;
      5'd3:  val = 8'd2;
      5'd4:  val = 8'd40;
      5'd5:  val = 8'd4;
      5'd6:  val = 8'd80;
      5'd7:  val = 8'd6;
      5'd8:  val = 8'd160;
      5'd9:  val = 8'd8;
      5'd10: val = 8'd60;
      5'd11: val = 8'd10;
      5'd12: val = 8'd14;
      5'd13: val = 8'd12;
      5'd14: val = 8'd26;
      5'd15: val = 8'd14;
      5'd16: val = 8'd12;
      5'd17: val = 8'd16;
      5'd18: val = 8'd24;
      5'd19: val = 8'd18;
      5'd20: val = 8'd48;
      5'd21: val = 8'd20;
      5'd22: val = 8'd96;
      5'd23: val = 8'd22;
      5'd24: val = 8'd192;
      5'd25: val = 8'd24;
      5'd26: val = 8'd72;
      5'd27: val = 8'd26;
      5'd28: val = 8'd16;
      5'd29: val = 8'd28;
      5'd30: val = 8'd32;
      default: val = 8'd30;
    endcase
    length_lookup = val;
  endfunction

endpackage

[src/twc_core.sv]
// Channel state and per-event update logic for the triangle wave channel.
// Depends on twc_pkg; the result is combinational from the updated state.
module twc_core
  import twc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  in_item_t  item_i,
  output out_item_t res_o
);

  logic [4:0]  step_q, step_d;
  logic [6:0]  linear_q, linear_d;
  logic [6:0]  reload_val_q, reload_val_d;
  logic        pend_q, pend_d;
  logic        halt_q, halt_d;
  logic [10:0] period_q, period_d;
  logic [7:0]  length_q, length_d;

  // Work out the state after the current event
  always_comb begin
    step_d       = step_q;
    linear_d     = linear_q;
    reload_val_d = reload_val_q;
    pend_d       = pend_q;
    halt_d       = halt_q;
    period_d     = period_q;
    length_d     = length_q;
    if (en_i) begin
      unique case (item_i.func)
        FUNC_WRITE: begin
          unique case (item_i.reg_addr)
            REG_LINEAR: begin
              halt_d       = item_i.write_data[7];
              reload_val_d = item_i.write_data[6:0];
            end
            REG_PERIOD_LO: period_d[7:0] = item_i.write_data;
            REG_UNUSED: ;
            REG_LENGTH: begin
              length_d       = length_lookup(item_i.write_data[7:3]);
              period_d[10:8] = item_i.write_data[2:0];
              pend_d         = 1'b1;
            end
          endcase
        end
        FUNC_TIMER: begin
          if (length_q != 8'd0 && linear_q != 7'd0) step_d = step_q + 5'd1;
        end
        FUNC_QUARTER: begin
          if (pend_q) linear_d = reload_val_q;
          else if (linear_q != 7'd0) linear_d = linear_q - 7'd1;
          if (!halt_q) pend_d = 1'b0;
        end
        FUNC_HALF: begin
          if (!halt_q && length_q != 8'd0) length_d = length_q - 8'd1;
        end
      endcase
    end
  end

  // Hold the channel state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q       <= '0;
      linear_q     <= '0;
      reload_val_q <= '0;
      pend_q       <= 1'b0;
      halt_q       <= 1'b0;
      period_q     <= '0;
      length_q     <= '0;
    end else begin
      step_q       <= step_d;
      linear_q     <= linear_d;
      reload_val_q <= reload_val_d;
      pend_q       <= pend_d;
      halt_q       <= halt_d;
      period_q     <= period_d;
      length_q     <= length_d;
    end
  end

  // Result is taken after the update
  assign res_o.level         = wave_level(step_d);
  assign res_o.timer_period  = period_d;
  assign res_o.length_active = (length_d != 8'd0);
  assign res_o.linear_active = (linear_d != 7'd0);

  a_length_write_arms_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && item_i.func == FUNC_WRITE && item_i.reg_addr == REG_LENGTH |=> pend_q)
    else $error("length write did not set the reload flag");

  a_timer_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && item_i.func == FUNC_TIMER && length_q != 8'd0 && linear_q != 7'd0
    |=> step_q == $past(step_q) + 5'd1)
    else $error("timer expiry with live counters did not advance the sequence");

  a_idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(step_q) && $stable(linear_q) && $stable(length_q)
              && $stable(period_q))
    else $error("channel state changed without an event");

endmodule

[src/triangle_wave_channel_top.sv]
// Top level of the triangle wave channel: input register, channel core and
// result register. Depends on twc_pkg and twc_core.
//
//   channel | direction | payload    | handshake
//   in      | input     | in_item_t  | in_valid_i / in_stall_o
//   out     | output    | out_item_t | out_valid_o / out_stall_i
//
// One item per cycle sustained while the output does not stall; the result of an
// accepted item passes through the input register, then the result register,
// before its output transfer.
// Reset clears the channel state and both valid flags.
// An output stall holds the result; the input register still takes one more
// transfer, and in_stall_o rises only when both registers are full and the
// output is stalled.
module triangle_wave_channel_top
  import twc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic      in_valid_q;
  in_item_t  in_item_q;
  logic      out_valid_q;
  out_item_t out_item_q;
  out_item_t res;
  logic      advance;

  // Move the held item into the core when the result register can take it
  assign advance    = in_valid_q && !(out_valid_q && out_stall_i);
  assign in_stall_o = in_valid_q && !advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) in_item_q <= in_item_i;
  end

  twc_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .item_i (in_item_q),
    .res_o  (res)
  );

  // Result register: load on advance, drop once the transfer completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) out_item_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

[bench/triangle_wave_channel_top_tb.sv]
// Self-checking bench for triangle_wave_channel_top: directed and random channel
// events with random idling on both sides, each result checked in order against
// a local model of the channel. Depends on twc_pkg and the channel RTL.
module triangle_wave_channel_top_tb;
  import twc_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned RANDOM_ITEMS = 1100;
  localparam int unsigned IDLE_PCT     = 37;
  localparam int unsigned MAX_REPORTS  = 10;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_item_o;

  // Local copy of the channel state
  logic [4:0]  wave_pos;
  logic [6:0]  lin_cnt;
  logic [6:0]  lin_reload;
  logic        reload_flag;
  logic        halt_flag;
  logic [10:0] period_reg;
  logic [7:0]  len_cnt;

  logic [7:0]  length_loads [32];
  out_item_t   predicted_outputs [$];

  bit          idle_on;
  int unsigned cycle_count;
  int unsigned events_sent;
  int unsigned results_seen;
  int unsigned error_count;
  int unsigned n_writes;
  int unsigned n_advances;
  int unsigned n_wraps;

  triangle_wave_channel_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Advance the model by one event and return the outputs it should show
  function automatic out_item_t apply_channel_event(input in_item_t ev);
    out_item_t res;
    case (ev.func)
      FUNC_WRITE: begin
        n_writes++;
        case (ev.reg_addr)
          REG_LINEAR: begin
            halt_flag  = ev.write_data[7];
            lin_reload = ev.write_data[6:0];
          end
          REG_PERIOD_LO: period_reg[7:0] = ev.write_data;
          REG_LENGTH: begin
            len_cnt          = length_loads[ev.write_data[7:3]];
            period_reg[10:8] = ev.write_data[2:0];
            reload_flag      = 1'b1;
          end
          default: ;
        endcase
      end
      FUNC_TIMER: begin
        if (len_cnt != 0 && lin_cnt != 0) begin
          n_advances++;
          if (wave_pos == 5'd31) n_wraps++;
          wave_pos = wave_pos + 5'd1;
        end
      end
      FUNC_QUARTER: begin
        if (reload_flag) lin_cnt = lin_reload;
        else if (lin_cnt != 0) lin_cnt = lin_cnt - 7'd1;
        if (!halt_flag) reload_flag = 1'b0;
      end
      default: begin
        if (!halt_flag && len_cnt != 0) len_cnt = len_cnt - 8'd1;
      end
    endcase
    res.level         = (wave_pos < 5'd16) ? 4'(5'd15 - wave_pos) : 4'(wave_pos - 5'd16);
    res.timer_period  = period_reg;
    res.length_active = (len_cnt != 0);
    res.linear_active = (lin_cnt != 0);
    return res;
  endfunction

  function automatic in_item_t make_event(input func_e f, input logic [1:0] addr,
                                          input logic [7:0] data);
    in_item_t ev;
    ev.func       = f;
    ev.reg_addr   = addr;
    ev.write_data = data;
    return ev;
  endfunction

  // Present one event from a falling edge, hold it until the transfer, return
  // at the next falling edge with valid still high
  task automatic send_event(input in_item_t ev);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i = 1'b0;
      in_item_i  = in_item_t'(12'($urandom));
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_item_i  = ev;
    do @(posedge clk_i); while (in_stall_o);
    predicted_outputs.push_back(apply_channel_event(ev));
    events_sent++;
    @(negedge clk_i);
  endtask

  // Output side: stall at random, except during the quiet stretch
  always @(negedge clk_i) begin
    out_stall_i = idle_on && ($urandom_range(99) < IDLE_PCT);
  end

  // Check each result transfer against the oldest prediction
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (predicted_outputs.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("result with nothing predicted: level=%0d period=%0d len=%0b lin=%0b",
                   out_item_o.level, out_item_o.timer_period,
                   out_item_o.length_active, out_item_o.linear_active);
      end else begin
        want = predicted_outputs.pop_front();
        if (out_item_o.level !== want.level ||
            out_item_o.timer_period !== want.timer_period ||
            out_item_o.length_active !== want.length_active ||
            out_item_o.linear_active !== want.linear_active) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display({"mismatch at result %0d: exp level=%0d period=%0d len=%0b lin=%0b,",
                      " got level=%0d period=%0d len=%0b lin=%0b"},
                     results_seen, want.level, want.timer_period, want.length_active,
                     want.linear_active, out_item_o.level, out_item_o.timer_period,
                     out_item_o.length_active, out_item_o.linear_active);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb: failure");
      $finish;
    end
  end

  // Register extremes, the unused address and both halves of the period
  task automatic test_register_writes;
    send_event(make_event(FUNC_WRITE, REG_LINEAR, 8'h00));
    send_event(make_event(FUNC_TIMER, 2'd0, 8'h00));
    send_event(make_event(FUNC_WRITE, REG_UNUSED, 8'hFF));
    send_event(make_event(FUNC_WRITE, REG_PERIOD_LO, 8'hFF));
    send_event(make_event(FUNC_WRITE, REG_LENGTH, 8'hFF));
    send_event(make_event(FUNC_WRITE, REG_PERIOD_LO, 8'h00));
  endtask

  // Linear counter: reload of zero, halt keeping the reload flag, count down
  task automatic test_linear_counter;
    send_event(make_event(FUNC_QUARTER, 2'd3, 8'hFF));
    send_event(make_event(FUNC_TIMER, 2'd3, 8'hFF));
    send_event(make_event(FUNC_WRITE, REG_LINEAR, 8'hFF));
    send_event(make_event(FUNC_WRITE, REG_LENGTH, 8'h08));
    send_event(make_event(FUNC_QUARTER, 2'd0, 8'h00));
    send_event(make_event(FUNC_TIMER, 2'd1, 8'h55));
    send_event(make_event(FUNC_HALF, 2'd2, 8'hAA));
    send_event(make_event(FUNC_QUARTER, 2'd0, 8'h00));
    send_event(make_event(FUNC_WRITE, REG_LINEAR, 8'h01));
    send_event(make_event(FUNC_QUARTER, 2'd0, 8'h00));
    send_event(make_event(FUNC_TIMER, 2'd0, 8'h00));
    send_event(make_event(FUNC_QUARTER, 2'd0, 8'h00));
    send_event(make_event(FUNC_QUARTER, 2'd0, 8'h00));
    send_event(make_event(FUNC_TIMER, 2'd0, 8'h00));
  endtask

  // Length counter: short load run down to zero and held there
  task automatic test_length_counter;
    send_event(make_event(FUNC_WRITE, REG_LENGTH, 8'h18));
    send_event(make_event(FUNC_HALF, 2'd0, 8'h00));
    send_event(make_event(FUNC_HALF, 2'd0, 8'h00));
    send_event(make_event(FUNC_HALF, 2'd0, 8'h00));
    send_event(make_event(FUNC_WRITE, REG_LENGTH, 8'h00));
  endtask

  // Mostly set-up sequences followed by weighted events, some pure noise
  task automatic test_random_traffic;
    int unsigned start_count;
    int unsigned burst;
    int unsigned pick;
    logic [7:0]  data;
    func_e       f;
    start_count = events_sent;
    while (events_sent - start_count < RANDOM_ITEMS) begin
      idle_on = !(events_sent - start_count >= 400 && events_sent - start_count < 700);
      if ($urandom_range(9) == 0) begin
        repeat (5) send_event(in_item_t'(12'($urandom)));
      end else begin
        data = 8'($urandom);
        data[7] = ($urandom_range(3) == 0);
        if ($urandom_range(1) == 0) data[6:0] = 7'($urandom_range(7));
        send_event(make_event(FUNC_WRITE, REG_LINEAR, data));
        send_event(make_event(FUNC_WRITE, REG_PERIOD_LO, 8'($urandom)));
        send_event(make_event(FUNC_WRITE, REG_LENGTH, 8'($urandom)));
        send_event(make_event(FUNC_QUARTER, 2'($urandom), 8'($urandom)));
        burst = $urandom_range(20, 40);
        repeat (burst) begin
          pick = $urandom_range(99);
          if (pick < 10)      f = FUNC_WRITE;
          else if (pick < 70) f = FUNC_TIMER;
          else if (pick < 85) f = FUNC_QUARTER;
          else                f = FUNC_HALF;
          send_event(make_event(f, 2'($urandom), 8'($urandom)));
        end
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    length_loads = '{8'd10, 8'd254, 8'd20, 8'd2, 8'd40, 8'd4, 8'd80, 8'd6,
                     8'd160, 8'd8, 8'd60, 8'd10, 8'd14, 8'd12, 8'd26, 8'd14,
                     8'd12, 8'd16, 8'd24, 8'd18, 8'd48, 8'd20, 8'd96, 8'd22,
                     8'd192, 8'd24, 8'd72, 8'd26, 8'd16, 8'd28, 8'd32, 8'd30};
    wave_pos     = '0;
    lin_cnt      = '0;
    lin_reload   = '0;
    reload_flag  = 1'b0;
    halt_flag    = 1'b0;
    period_reg   = '0;
    len_cnt      = '0;
    idle_on      = 1'b1;
    cycle_count  = 0;
    events_sent  = 0;
    results_seen = 0;
    error_count  = 0;
    n_writes     = 0;
    n_advances   = 0;
    n_wraps      = 0;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_item_i    = '0;
    out_stall_i  = 1'b0;

    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_register_writes();
    test_linear_counter();
    test_length_counter();
    test_random_traffic();

    // Drain: wait for every predicted result, then keep watching for strays
    in_valid_i = 1'b0;
    while (predicted_outputs.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);

    $display("covered %0d events (%0d register writes), %0d results checked",
             events_sent, n_writes, results_seen);
    $display("sequence advanced %0d times with %0d wraps, %0d errors",
             n_advances, n_wraps, error_count);
    if (error_count == 0 && predicted_outputs.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
